FILE: rtl/chs_pkg.sv
// Package: sizes, transaction types and operation codes for the chained hash set.
`timescale 1ns / 1ps
package chs_pkg;

  localparam int BUCKETS      = 16;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_WIDTH    = 32;

  localparam int HASH_W   = 31;
  localparam int CFG_W    = 5;
  localparam int BIDX_W   = 4;
  localparam int COLL_W   = 16;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOT_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int DIV_W    = BUCKET_W + 1;
  localparam int ADDR_W   = BUCKET_W + SLOT_W;
  localparam int STORE_DEPTH = BUCKETS * BUCKET_DEPTH;
  localparam int STEP_W   = $clog2(HASH_W);

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(11);
  localparam logic [COLL_W-1:0] COLL_MAX  = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } chs_op_t;

  typedef enum logic {
    ST_DONE    = 1'b0,
    ST_DROPPED = 1'b1
  } chs_status_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key;
    logic [HASH_W-1:0]  hash_key;
  } chs_req_t;

  typedef struct packed {
    logic              found;
    logic [BIDX_W-1:0] bucket_index;
    logic              status;
    logic [COLL_W-1:0] collisions;
  } chs_rsp_t;

endpackage

FILE: rtl/chs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/chs_divider.sv
// Bit-serial restoring remainder unit: hash key modulo the bucket count.
`timescale 1ns / 1ps
module chs_divider
  import chs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [HASH_W-1:0]   dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                done,
  output logic [BUCKET_W-1:0] remainder
);

  logic                running;
  logic [STEP_W-1:0]   step;
  logic [HASH_W-1:0]   shreg;
  logic [DIV_W-1:0]    dsr;
  logic [DIV_W-1:0]    trial;
  logic [DIV_W-1:0]    diff;

  // one quotient bit per cycle, MSB first; remainder stays below divisor
  assign trial = {remainder, shreg[HASH_W-1]};
  assign diff  = trial - dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dsr       <= divisor;
      remainder <= '0;
      step      <= STEP_W'(HASH_W - 1);
    end else if (running) begin
      shreg <= shreg << 1;
      step  <= step - 1'b1;
      if (trial >= dsr) begin
        remainder <= diff[BUCKET_W-1:0];
      end else begin
        remainder <= trial[BUCKET_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/chained_hash_set.sv
// Top level: hash set with separate chaining over fixed-depth buckets.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result appears. The result sits on rsp for exactly one cycle
// with done high and cannot be held off, so the receiver must take it then.
// busy is already low in that cycle, so the next transaction may start at the
// same edge. The bucket is hash_key modulo bucket_count, worked out by a
// bit-serial remainder unit at one bit per cycle for every transaction. An
// insert then finishes in the lookup step. A search reads its bucket from
// the key RAM one entry at a time (registered read, then compare), stopping
// at the first match. The user must write bucket_count via cfg_we/cfg_wdata
// only while idle; the block does not enforce it. 0 acts as 1 and values
// above 16 act as 16. Keys left beyond a lowered bucket count stay put.
// Inserts into a non-empty bucket bump a saturating collision count, even
// when the bucket is full and the key is dropped (status set). No clearing
// pass is needed after reset: only entries below a bucket's fill count are
// ever read.
module chained_hash_set
  import chs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  chs_req_t         req,
  output logic             done,
  output chs_rsp_t         rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HASH   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_READ   = 5'b01000,
    S_CMP    = 5'b10000
  } state_t;

  state_t              state;
  chs_req_t            req_q;
  logic [CFG_W-1:0]    bucket_count;
  logic [BUCKET_W-1:0] bkt;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   slot;
  logic [COLL_W-1:0]   collision_total;
  logic [FILL_W-1:0]   bucket_fill [BUCKETS];

  logic [DIV_W-1:0]    eff_count;
  logic                div_start;
  logic                div_done;
  logic [BUCKET_W-1:0] div_rem;

  logic [FILL_W-1:0]   fill_now;
  logic [COLL_W-1:0]   collision_next;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic                key_hit;
  logic                last_slot;

  // clamp the configured count to 1..BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      eff_count = DIV_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      eff_count = DIV_W'(BUCKETS);
    end else begin
      eff_count = DIV_W'(bucket_count);
    end
  end

  assign busy      = (state != S_IDLE);
  assign div_start = (state == S_IDLE) && start;

  chs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.hash_key),
    .divisor   (eff_count),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign fill_now = bucket_fill[bkt];

  // inserting into a bucket that already holds keys counts as a collision
  always_comb begin
    collision_next = collision_total;
    if (fill_now != '0 && collision_total != COLL_MAX) begin
      collision_next = collision_total + 1'b1;
    end
  end

  assign ram_we    = (state == S_LOOKUP) && (req_q.op == OP_INSERT) &&
                     (32'(fill_now) < BUCKET_DEPTH);
  assign ram_waddr = {bkt, fill_now[SLOT_W-1:0]};
  assign ram_raddr = {bkt, slot[SLOT_W-1:0]};

  chs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_q.key[KEY_WIDTH-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_hit   = (ram_rdata == req_q.key[KEY_WIDTH-1:0]);
  assign last_slot = ((slot + 1'b1) == fill_q);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      collision_total <= '0;
      bucket_count    <= CFG_RESET;
      for (int i = 0; i < BUCKETS; i++) begin
        bucket_fill[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        bucket_count <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (div_done) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (req_q.op == OP_INSERT) begin
            collision_total <= collision_next;
            if (ram_we) begin
              bucket_fill[bkt] <= fill_now + 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (fill_now == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (key_hit || last_slot) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          req_q <= req;
        end
      end
      S_HASH: begin
        if (div_done) begin
          bkt <= div_rem;
        end
      end
      S_LOOKUP: begin
        slot   <= '0;
        fill_q <= fill_now;
        rsp.found        <= 1'b0;
        rsp.bucket_index <= BIDX_W'(bkt);
        rsp.status       <= ST_DONE;
        rsp.collisions   <= collision_total;
        if (req_q.op == OP_INSERT) begin
          rsp.collisions <= collision_next;
          if (!ram_we) begin
            rsp.status <= ST_DROPPED;
          end
        end
      end
      S_CMP: begin
        slot      <= slot + 1'b1;
        rsp.found <= key_hit;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/chs_checker.sv
// Port-level checker for the chained hash set, bound to the top level.
`timescale 1ns / 1ps
module chs_checker
  import chs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input chs_rsp_t rsp
);

  // result strobe only when the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  // busy only drops together with a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  // a result is never both a hit and a drop: a search never drops, an insert never reports a hit
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.found && rsp.status == ST_DROPPED))
    else $error("found and dropped together");

  // a dropped insert hit a non-empty bucket, so the count cannot be zero
  a_drop_coll: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_DROPPED) |-> (rsp.collisions != '0))
    else $error("dropped insert with zero collision count");

endmodule

bind chained_hash_set chs_checker u_chk (.*);

FILE: tb/chained_hash_set_test.sv
// Self-checking testbench for the chained hash set: directed table, then random phases.
`timescale 1ns / 1ps
module chained_hash_set_test;
  import chs_pkg::*;

  // Slowest transaction is a search over a full bucket, plus the sender's own idle
  // cycles; this limit leaves a wide margin over that.
  localparam int QUIET_LIMIT = 5000;
  // Cycles allowed for a stray result after the last expected one has arrived.
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 145;
  localparam int PHASES      = 10;
  localparam int RECENT_MAX  = 48;

  // One line of the directed script: either a bucket_count write or a transaction,
  // the latter optionally with its result typed in by hand.
  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg;
    chs_req_t         rq;
    logic             typed;
    chs_rsp_t         rsp;
  } script_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  chs_req_t         req       = '0;
  logic             done;
  chs_rsp_t         rsp;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Hand-written expectation that travels alongside the transaction on req
  logic     req_typed     = 1'b0;
  chs_rsp_t req_typed_rsp = '0;

  // Mirror of the set: keys per bucket, fill per bucket, collision count, register
  logic [31:0]       held_keys [BUCKETS][BUCKET_DEPTH];
  int unsigned       fill_level [BUCKETS];
  logic [COLL_W-1:0] coll_total     = '0;
  logic [CFG_W-1:0]  mirror_buckets = CFG_RESET;

  script_row_t script [$];
  chs_rsp_t    pending_rsp [$];
  chs_req_t    recent_inserts [$];
  int unsigned issued       = 0;
  int unsigned answered     = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 33;

  chained_hash_set uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Works out the result of one transaction and moves the mirror on.
  // Bucket count 0 behaves as 1, anything above BUCKETS as BUCKETS.
  function automatic chs_rsp_t set_outcome(chs_req_t r);
    chs_rsp_t    res;
    int unsigned n;
    int unsigned b;
    int unsigned fill;
    int unsigned i;
    n = 32'(mirror_buckets);
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    b = r.hash_key % n;
    fill = fill_level[b];
    res = '0;
    res.bucket_index = BIDX_W'(b);
    if (r.op == OP_INSERT) begin
      // a full bucket still counts as a collision, the key is just dropped
      if (fill != 0 && coll_total != COLL_MAX) coll_total++;
      if (fill >= BUCKET_DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        held_keys[b][fill] = r.key;
        fill_level[b] = fill + 1;
      end
    end else begin
      for (i = 0; i < fill; i++)
        if (held_keys[b][i] == r.key) res.found = 1'b1;
    end
    res.collisions = coll_total;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result checking and prediction, all on the rising edge with pre-edge values.
  always @(posedge clk) begin
    chs_rsp_t want;
    chs_rsp_t guess;
    if (!rst) begin
      if (cfg_we) mirror_buckets = cfg_wdata;
      if (done) begin
        answered++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction pending, got %p", $time, rsp);
        end else begin
          want = pending_rsp.pop_front();
          check_field("found", 32'(want.found), 32'(rsp.found));
          check_field("bucket_index", 32'(want.bucket_index), 32'(rsp.bucket_index));
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("collisions", 32'(want.collisions), 32'(rsp.collisions));
        end
      end
      if (start && !busy) begin
        // mirror always advances; a typed-in row overrides the predicted value
        guess = set_outcome(req);
        pending_rsp.insert(pending_rsp.size(), req_typed ? req_typed_rsp : guess);
      end
      quiet_cycles = (done || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  // Present one transaction and hold it until taken. Start drops at random
  // cycles, so idle gaps land both while busy and at the moment it frees up.
  task automatic issue(chs_req_t r, logic typed, chs_rsp_t typed_rsp);
    logic taken;
    taken = 1'b0;
    req           <= r;
    req_typed     <= typed;
    req_typed_rsp <= typed_rsp;
    while (!taken) begin
      start <= ($urandom_range(0, 99) >= idle_pct);
      @(posedge clk);
      taken = start && !busy;
    end
    issued++;
  endtask

  // Let the block go idle: every outstanding result back, nothing presented.
  task automatic settle();
    start <= 1'b0;
    while (answered != issued) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random transaction. About half reuse a recent insert's key (mostly with its
  // hash too) so searches hit and duplicates pile up; some use extreme keys.
  function automatic chs_req_t random_request();
    chs_req_t    r;
    chs_req_t    prior;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    r.op       = ($urandom_range(0, 1) != 0) ? OP_SEARCH : OP_INSERT;
    r.key      = $urandom;
    r.hash_key = HASH_W'($urandom);
    if (pick < 50 && recent_inserts.size() != 0) begin
      prior = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
      r.key = prior.key;
      if (pick < 40) r.hash_key = prior.hash_key;
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: r.key = 32'h0000_0000;
        1: r.key = 32'hFFFF_FFFF;
        2: r.key = 32'h8000_0000;
        default: r.key = 32'h7FFF_FFFF;
      endcase
      if ($urandom_range(0, 3) == 0) r.hash_key = {HASH_W{1'b1}};
      else r.hash_key = HASH_W'($urandom_range(0, 40));
    end
    if (r.op == OP_INSERT) begin
      recent_inserts.insert(recent_inserts.size(), r);
      if (recent_inserts.size() > RECENT_MAX) void'(recent_inserts.pop_front());
    end
    return r;
  endfunction

  function automatic script_row_t plain_row(chs_op_t op, logic [31:0] key,
                                            logic [HASH_W-1:0] hk);
    script_row_t s;
    s             = '0;
    s.rq.op       = op;
    s.rq.key      = key;
    s.rq.hash_key = hk;
    return s;
  endfunction

  function automatic script_row_t checked_row(chs_op_t op, logic [31:0] key,
                                              logic [HASH_W-1:0] hk, logic f,
                                              int unsigned bidx, chs_status_t st,
                                              int unsigned coll);
    script_row_t s;
    s                  = plain_row(op, key, hk);
    s.typed            = 1'b1;
    s.rsp.found        = f;
    s.rsp.bucket_index = BIDX_W'(bidx);
    s.rsp.status       = st;
    s.rsp.collisions   = COLL_W'(coll);
    return s;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_W-1:0] v);
    script_row_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.cfg    = v;
    return s;
  endfunction

  function automatic void add_row(script_row_t s);
    script.insert(script.size(), s);
  endfunction

  // Watchdog: too long with nothing taken in either direction.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] v;
    int               p;

    // Directed script, bucket count 11 out of reset.
    // Empty bucket search, then the extreme key/hash pair (2^31-1 mod 11 = 1).
    add_row(checked_row(OP_SEARCH, 32'h0000_0000, 31'd0, 1'b0, 0, ST_DONE, 0));
    add_row(checked_row(OP_INSERT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 1, ST_DONE, 0));
    add_row(checked_row(OP_SEARCH, 32'h8000_0000, 31'd1, 1'b1, 1, ST_DONE, 0));
    add_row(checked_row(OP_SEARCH, 32'h7FFF_FFFF, 31'd12, 1'b0, 1, ST_DONE, 0));
    // Fill bucket 3 to the brim, a duplicate among them; each later insert collides
    add_row(checked_row(OP_INSERT, 32'h0000_0001, 31'd3, 1'b0, 3, ST_DONE, 0));
    add_row(checked_row(OP_INSERT, 32'hFFFF_FFFF, 31'd14, 1'b0, 3, ST_DONE, 1));
    add_row(checked_row(OP_INSERT, 32'h5555_5555, 31'd25, 1'b0, 3, ST_DONE, 2));
    add_row(checked_row(OP_INSERT, 32'hAAAA_AAAA, 31'd36, 1'b0, 3, ST_DONE, 3));
    add_row(checked_row(OP_INSERT, 32'h0000_0001, 31'd47, 1'b0, 3, ST_DONE, 4));
    add_row(checked_row(OP_INSERT, 32'h1234_5678, 31'd58, 1'b0, 3, ST_DONE, 5));
    add_row(checked_row(OP_INSERT, 32'hFFFF_FFFE, 31'd69, 1'b0, 3, ST_DONE, 6));
    add_row(checked_row(OP_INSERT, 32'h0F0F_0F0F, 31'd80, 1'b0, 3, ST_DONE, 7));
    // Full bucket: dropped, yet the collision count still moves
    add_row(checked_row(OP_INSERT, 32'hDEAD_BEEF, 31'd91, 1'b0, 3, ST_DROPPED, 8));
    add_row(checked_row(OP_SEARCH, 32'h0F0F_0F0F, 31'd3, 1'b1, 3, ST_DONE, 8));
    add_row(checked_row(OP_SEARCH, 32'hDEAD_BEEF, 31'd3, 1'b0, 3, ST_DONE, 8));
    add_row(checked_row(OP_INSERT, 32'h7FFF_FFFF, 31'd10, 1'b0, 10, ST_DONE, 8));
    add_row(checked_row(OP_SEARCH, 32'hFFFF_FFFF, 31'd10, 1'b0, 10, ST_DONE, 8));
    // Bucket count zero behaves as one
    add_row(cfg_row(CFG_W'(0)));
    add_row(checked_row(OP_INSERT, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0, 0, ST_DONE, 8));
    add_row(checked_row(OP_SEARCH, 32'h0000_0000, 31'h1234_5678, 1'b1, 0, ST_DONE, 8));
    // Above the bucket limit behaves as sixteen; stale keys stay where they were
    add_row(cfg_row(CFG_W'(31)));
    add_row(checked_row(OP_INSERT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 15, ST_DONE, 8));
    add_row(checked_row(OP_SEARCH, 32'h7FFF_FFFF, 31'd26, 1'b1, 10, ST_DONE, 8));
    add_row(checked_row(OP_SEARCH, 32'h5555_5555, 31'd19, 1'b1, 3, ST_DONE, 8));
    add_row(cfg_row(CFG_W'(16)));
    add_row(plain_row(OP_INSERT, 32'h4000_0000, 31'h4000_0000));
    add_row(plain_row(OP_SEARCH, 32'h4000_0000, 31'h2AAA_AAA0));
    add_row(cfg_row(CFG_W'(1)));
    add_row(plain_row(OP_SEARCH, 32'h0000_0000, 31'h5555_5555));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_bucket_count(script[i].cfg);
      else issue(script[i].rq, script[i].typed, script[i].rsp);
    end

    // Random phases over a spread of bucket counts, extremes included.
    // Phase 4 runs with no idle cycles at all.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: v = CFG_W'(1);
        1: v = CFG_W'(16);
        2: v = CFG_W'(0);
        3: v = CFG_W'(31);
        4: v = CFG_W'(11);
        9: v = CFG_W'(16);
        default: v = CFG_W'($urandom_range(0, 31));
      endcase
      idle_pct = (p == 4) ? 0 : 33;
      write_bucket_count(v);
      repeat (PHASE_ITEMS) issue(random_request(), 1'b0, '0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_rsp.size());
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chs_divider.sv
rtl/chained_hash_set.sv
rtl/chs_checker.sv
tb/chained_hash_set_test.sv
